@@ hw/rtl/ole_pkg.sv @@
`default_nettype none

package ole_pkg;

    localparam int CAPACITY_DEF = 32;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_INS_POS = 3'd1,
        OP_INS_ID  = 3'd2,
        OP_DEL_POS = 3'd3,
        OP_DEL_ID  = 3'd4,
        OP_DUMP    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [4:0]         position;
        logic signed [31:0] entry_id;
        logic signed [31:0] key_id;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_id;
        logic [4:0]         out_index;
        logic               entry_valid;
        logic [5:0]         count;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/ole_mem.sv @@
`default_nettype none

module ole_mem #(
    parameter int DEPTH = ole_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/ordered_list_engine.sv @@
`default_nettype none

// Ordered list of up to CAPACITY signed ids held in one single-port-read,
// single-port-write RAM, in list order. A request is taken when start is high
// and busy is low. Every request except a dump gives one result; a dump gives
// one result per entry on consecutive cycles (one for an empty list), with
// last set on the final one. Results appear in the cycle after the decision,
// strobed by result_strobe for one cycle each; there is no way to hold them
// off, so the receiver must take them as they come. Timing is set by the RAM
// walk, one entry a cycle: a rejected request, an empty dump or an unused op
// code is decided in the accept cycle and never raises busy; an append writes
// its entry at the tail directly; insert at position moves each entry from the
// tail down to the position up by one, then writes the new entry; delete at
// position moves each later entry down by one; a search op reads from the head
// until a match or the end, then does its shift; a dump reads every entry in
// order. The longest request is a delete by id on a full list.
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ole_pkg::req_t req,
    output ole_pkg::res_t      result,
    output logic               result_strobe
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ole_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      cur_reg, cur_next;
    logic [CW-1:0]      at_reg, at_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      wa_reg, wa_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic [2:0]         op_reg, op_next;
    logic [31:0]        eid_reg, eid_next;
    logic [31:0]        key_reg, key_next;
    ole_pkg::res_t      res_reg, res_next;
    logic               res_vld_reg, res_vld_next;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    // accept decode
    logic               accept;
    logic               full;
    logic               badpos;
    ole_pkg::state_t    acc_state;
    ole_pkg::status_t   acc_status;
    logic [CW-1:0]      acc_at;
    logic [CW-1:0]      acc_cur;

    logic               issue_up;
    logic               issue_dn;
    logic               issue_rd;
    logic               match;
    logic               miss;
    logic               idx_last;
    logic [CW-1:0]      rd_idx_ext;

    assign accept     = start && (state_reg == ole_pkg::S_IDLE);
    assign full       = 32'(count_reg) >= 32'(CAPACITY);
    assign badpos     = {27'b0, req.position} >= 32'(count_reg);
    assign rd_idx_ext = CW'(rd_idx_reg);
    assign issue_up   = cur_reg > at_reg;
    assign issue_dn   = (32'(cur_reg) + 32'd1) < 32'(count_reg);
    assign issue_rd   = cur_reg < count_reg;
    assign match      = rd_vld_reg && (mem_rdata == key_reg);
    assign miss       = !match && !issue_rd;
    assign idx_last   = (rd_idx_ext + CW'(1)) == count_reg;

    always_comb
    begin
        acc_state  = ole_pkg::S_IDLE;
        acc_status = ole_pkg::ST_OK;
        acc_at     = count_reg;
        acc_cur    = count_reg;
        unique case (req.op)
            ole_pkg::OP_APPEND:
            begin
                if (full)
                    acc_status = ole_pkg::ST_FULL;
                else
                    acc_state = ole_pkg::S_SHIFT_UP;
            end
            ole_pkg::OP_INS_POS:
            begin
                if (full)
                    acc_status = ole_pkg::ST_FULL;
                else if (badpos)
                    acc_status = ole_pkg::ST_BADPOS;
                else
                begin
                    acc_state = ole_pkg::S_SHIFT_UP;
                    acc_at    = CW'(req.position);
                end
            end
            ole_pkg::OP_INS_ID:
            begin
                if (full)
                    acc_status = ole_pkg::ST_FULL;
                else
                begin
                    acc_state = ole_pkg::S_SEARCH;
                    acc_cur   = '0;
                end
            end
            ole_pkg::OP_DEL_POS:
            begin
                if (badpos)
                    acc_status = ole_pkg::ST_BADPOS;
                else
                begin
                    acc_state = ole_pkg::S_SHIFT_DN;
                    acc_cur   = CW'(req.position);
                end
            end
            ole_pkg::OP_DEL_ID:
            begin
                acc_state = ole_pkg::S_SEARCH;
                acc_cur   = '0;
            end
            ole_pkg::OP_DUMP:
            begin
                if (count_reg != '0)
                begin
                    acc_state = ole_pkg::S_DUMP;
                    acc_cur   = '0;
                end
            end
            default:
            begin
                acc_state = ole_pkg::S_IDLE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (start)
                    state_next = acc_state;
            end
            ole_pkg::S_SEARCH:
            begin
                if (match)
                    state_next = (op_reg == ole_pkg::OP_INS_ID) ? ole_pkg::S_SHIFT_UP
                                                                : ole_pkg::S_SHIFT_DN;
                else if (miss)
                    state_next = ole_pkg::S_IDLE;
            end
            ole_pkg::S_SHIFT_UP:
            begin
                if (!issue_up && !pend_reg)
                    state_next = ole_pkg::S_IDLE;
            end
            ole_pkg::S_SHIFT_DN:
            begin
                if (!issue_dn && !pend_reg)
                    state_next = ole_pkg::S_IDLE;
            end
            ole_pkg::S_DUMP:
            begin
                if (rd_vld_reg && idx_last)
                    state_next = ole_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next   = count_reg;
        cur_next     = cur_reg;
        at_next      = at_reg;
        pend_next    = 1'b0;
        wa_next      = wa_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        op_next      = op_reg;
        eid_next     = eid_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        res_vld_next = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = wa_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = cur_reg[IW-1:0];

        // drain a pending shift move
        if (pend_reg)
            mem_we = 1'b1;

        unique case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.op;
                    eid_next = req.entry_id;
                    key_next = req.key_id;
                    at_next  = acc_at;
                    cur_next = acc_cur;
                    if (acc_state == ole_pkg::S_IDLE)
                    begin
                        res_vld_next         = 1'b1;
                        res_next.status      = acc_status;
                        res_next.out_id      = '0;
                        res_next.out_index   = '0;
                        res_next.entry_valid = 1'b0;
                        res_next.count       = 6'(count_reg);
                        res_next.last        = 1'b1;
                    end
                end
            end
            ole_pkg::S_SEARCH:
            begin
                if (match)
                begin
                    if (op_reg == ole_pkg::OP_INS_ID)
                    begin
                        at_next  = rd_idx_ext + CW'(1);
                        cur_next = count_reg;
                    end
                    else
                    begin
                        at_next  = rd_idx_ext;
                        cur_next = rd_idx_ext;
                    end
                end
                else if (miss)
                begin
                    res_vld_next         = 1'b1;
                    res_next.status      = ole_pkg::ST_NOTFOUND;
                    res_next.out_id      = '0;
                    res_next.out_index   = '0;
                    res_next.entry_valid = 1'b0;
                    res_next.count       = 6'(count_reg);
                    res_next.last        = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cur_reg[IW-1:0];
                    cur_next    = cur_reg + CW'(1);
                end
            end
            ole_pkg::S_SHIFT_UP:
            begin
                mem_raddr = IW'(cur_reg - CW'(1));
                if (issue_up)
                begin
                    pend_next = 1'b1;
                    wa_next   = cur_reg[IW-1:0];
                    cur_next  = cur_reg - CW'(1);
                end
                else if (!pend_reg)
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = at_reg[IW-1:0];
                    mem_wdata            = eid_reg;
                    count_next           = count_reg + CW'(1);
                    res_vld_next         = 1'b1;
                    res_next.status      = ole_pkg::ST_OK;
                    res_next.out_id      = '0;
                    res_next.out_index   = '0;
                    res_next.entry_valid = 1'b0;
                    res_next.count       = 6'(count_reg + CW'(1));
                    res_next.last        = 1'b1;
                end
            end
            ole_pkg::S_SHIFT_DN:
            begin
                mem_raddr = IW'(cur_reg + CW'(1));
                if (issue_dn)
                begin
                    pend_next = 1'b1;
                    wa_next   = cur_reg[IW-1:0];
                    cur_next  = cur_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next           = count_reg - CW'(1);
                    res_vld_next         = 1'b1;
                    res_next.status      = ole_pkg::ST_OK;
                    res_next.out_id      = '0;
                    res_next.out_index   = '0;
                    res_next.entry_valid = 1'b0;
                    res_next.count       = 6'(count_reg - CW'(1));
                    res_next.last        = 1'b1;
                end
            end
            ole_pkg::S_DUMP:
            begin
                if (issue_rd)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cur_reg[IW-1:0];
                    cur_next    = cur_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    res_vld_next         = 1'b1;
                    res_next.status      = ole_pkg::ST_OK;
                    res_next.out_id      = mem_rdata;
                    res_next.out_index   = 5'(rd_idx_reg);
                    res_next.entry_valid = 1'b1;
                    res_next.count       = 6'(count_reg);
                    res_next.last        = idx_last;
                end
            end
            default:
            begin
                res_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ole_pkg::S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            rd_vld_reg  <= rd_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        at_reg     <= at_next;
        wa_reg     <= wa_next;
        rd_idx_reg <= rd_idx_next;
        op_reg     <= op_next;
        eid_reg    <= eid_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
    end

    ole_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy          = state_reg != ole_pkg::S_IDLE;
    assign result        = res_reg;
    assign result_strobe = res_vld_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ole_checker.sv @@
`default_nettype none

module ole_checker #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire ole_pkg::req_t req,
    input wire ole_pkg::res_t result,
    input wire logic          result_strobe
);

    // a dump streams without gaps until its last entry
    a_dump_contig: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |=> result_strobe)
        else $error("dump stream broke before last");

    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.entry_valid |-> result.status == ole_pkg::ST_OK)
        else $error("dumped entry with bad status");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.entry_valid |-> result.last)
        else $error("non-dump result without last");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> 32'(result.count) <= 32'(CAPACITY))
        else $error("count above capacity");

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

`default_nettype wire

@@ dv/list_checker.sv @@
`timescale 1ns / 100ps

module list_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire ole_pkg::req_t req,
    input  wire ole_pkg::res_t result,
    input  wire logic          result_strobe,
    output int                 fail_count,
    output int                 pending,
    output int                 dumps_seen,
    output int                 results_seen
);

    localparam int CAP = ole_pkg::CAPACITY_DEF;

    logic signed [31:0] list_ids [CAP];
    int                 list_len;
    ole_pkg::res_t      expected_results [$];

    initial begin
        fail_count   = 0;
        dumps_seen   = 0;
        results_seen = 0;
        list_len     = 0;
    end

    assign pending = expected_results.size();

    function automatic ole_pkg::res_t single_result(ole_pkg::status_t st);
        ole_pkg::res_t r;
        r = '0;
        r.status = st;
        r.count  = list_len[5:0];
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic int find_first(logic signed [31:0] key);
        for (int i = 0; i < list_len; i++)
            if (list_ids[i] == key)
                return i;
        return -1;
    endfunction

    task automatic insert_at(int at, logic signed [31:0] id);
        for (int i = list_len; i > at; i--)
            list_ids[i] = list_ids[i - 1];
        list_ids[at] = id;
        list_len++;
    endtask

    task automatic remove_at(int at);
        for (int i = at; i + 1 < list_len; i++)
            list_ids[i] = list_ids[i + 1];
        list_len--;
    endtask

    task automatic predict_list_op(ole_pkg::req_t rq);
        ole_pkg::res_t r;
        int            hit;
        int            pos;
        bit            full;
        full = (list_len >= CAP);
        hit  = find_first(rq.key_id);
        pos  = int'(rq.position);
        case (rq.op)
            ole_pkg::OP_APPEND:
                if (full) expected_results.push_back(single_result(ole_pkg::ST_FULL));
                else
                begin
                    insert_at(list_len, rq.entry_id);
                    expected_results.push_back(single_result(ole_pkg::ST_OK));
                end
            ole_pkg::OP_INS_POS:
                if (full) expected_results.push_back(single_result(ole_pkg::ST_FULL));
                else if (pos >= list_len)
                    expected_results.push_back(single_result(ole_pkg::ST_BADPOS));
                else
                begin
                    insert_at(pos, rq.entry_id);
                    expected_results.push_back(single_result(ole_pkg::ST_OK));
                end
            ole_pkg::OP_INS_ID:
                if (full) expected_results.push_back(single_result(ole_pkg::ST_FULL));
                else if (hit < 0)
                    expected_results.push_back(single_result(ole_pkg::ST_NOTFOUND));
                else
                begin
                    insert_at(hit + 1, rq.entry_id);
                    expected_results.push_back(single_result(ole_pkg::ST_OK));
                end
            ole_pkg::OP_DEL_POS:
                if (pos >= list_len)
                    expected_results.push_back(single_result(ole_pkg::ST_BADPOS));
                else
                begin
                    remove_at(pos);
                    expected_results.push_back(single_result(ole_pkg::ST_OK));
                end
            ole_pkg::OP_DEL_ID:
                if (hit < 0)
                    expected_results.push_back(single_result(ole_pkg::ST_NOTFOUND));
                else
                begin
                    remove_at(hit);
                    expected_results.push_back(single_result(ole_pkg::ST_OK));
                end
            ole_pkg::OP_DUMP:
            begin
                dumps_seen++;
                if (list_len == 0)
                    expected_results.push_back(single_result(ole_pkg::ST_OK));
                for (int i = 0; i < list_len; i++)
                begin
                    r = single_result(ole_pkg::ST_OK);
                    r.out_id      = list_ids[i];
                    r.out_index   = i[4:0];
                    r.entry_valid = 1'b1;
                    r.last        = (i + 1 == list_len);
                    expected_results.push_back(r);
                end
            end
            default:
                expected_results.push_back(single_result(ole_pkg::ST_OK));
        endcase
    endtask

    // Compare first, then predict: a result never comes from the request
    // taken at the same edge.
    always @(posedge clk)
    begin
        ole_pkg::res_t want;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status || result.out_id !== want.out_id
                        || result.out_index !== want.out_index
                        || result.entry_valid !== want.entry_valid
                        || result.count !== want.count || result.last !== want.last)
                    begin
                        $display("%0t: expected %p actual %p", $time, want, result);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_list_op(req);
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic          result_strobe;
    ole_pkg::req_t req = '0;
    ole_pkg::res_t result;
    int            fail_count;
    int            pending;
    int            dumps_seen;
    int            results_seen;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ordered_list_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result       (result),
        .result_strobe(result_strobe)
    );

    list_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result       (result),
        .result_strobe(result_strobe),
        .fail_count   (fail_count),
        .pending      (pending),
        .dumps_seen   (dumps_seen),
        .results_seen (results_seen)
    );

    int burst_left = 0;
    int requests_sent = 0;

    function automatic logic signed [31:0] pick_id();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return $signed($urandom_range(0, 15)) - 32'sd8;
        endcase
    endfunction

    // Hold the request until the engine takes it; drop start only when a gap
    // follows the burst.
    task automatic send_request(logic [2:0] op, logic [4:0] pos,
                                logic signed [31:0] eid, logic signed [31:0] key);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 40);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req   <= {op, pos, eid, key};
        start <= 1'b1;
        do @(posedge clk); while (busy);
        requests_sent++;
        burst_left--;
    endtask

    initial
    begin
        logic [2:0]  op;
        int          fill_goal;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ole_pkg::OP_DUMP, 5'd0, 0, 0);
        send_request(ole_pkg::OP_DEL_POS, 5'd0, 0, 0);
        send_request(ole_pkg::OP_INS_POS, 5'd0, 32'sd5, 0);
        send_request(ole_pkg::OP_DEL_ID, 5'd0, 0, 32'sd5);
        send_request(ole_pkg::OP_INS_ID, 5'd0, 32'sd5, 32'sd5);
        send_request(ole_pkg::OP_APPEND, 5'd0, 32'sh8000_0000, 0);
        send_request(ole_pkg::OP_APPEND, 5'd0, 32'sh7fff_ffff, 0);
        send_request(ole_pkg::OP_INS_POS, 5'd0, -32'sd1, 0);
        send_request(ole_pkg::OP_INS_POS, 5'd31, 32'sh5555_aaaa, 0);
        send_request(ole_pkg::OP_INS_ID, 5'd0, 32'shaaaa_5555, 32'sh8000_0000);
        send_request(ole_pkg::OP_INS_ID, 5'd0, 32'sd1, 32'sd9);
        send_request(ole_pkg::OP_DUMP, 5'd0, 0, 0);
        send_request(3'd6, 5'd31, -32'sd1, -32'sd1);
        send_request(3'd7, 5'd0, 0, 0);
        send_request(ole_pkg::OP_DEL_POS, 5'd0, 0, 0);
        send_request(ole_pkg::OP_DEL_ID, 5'd0, 0, 32'sh7fff_ffff);
        send_request(ole_pkg::OP_DEL_POS, 5'd1, 0, 0);
        send_request(ole_pkg::OP_DUMP, 5'd0, 0, 0);
        for (int i = 0; i < 33; i++)
            send_request(ole_pkg::OP_APPEND, 5'(i), 32'(i * 32'h0813_7f01), 0);
        send_request(ole_pkg::OP_INS_POS, 5'd31, 0, 0);
        send_request(ole_pkg::OP_INS_ID, 5'd0, 0, 32'sd0);
        send_request(ole_pkg::OP_DUMP, 5'd0, 0, 0);
        send_request(ole_pkg::OP_DEL_POS, 5'd31, 0, 0);

        // Random part: wander the fill level up and down between phases.
        for (int n = 0; n < 355; n++)
        begin
            fill_goal = (n / 60) % 2 ? 4 : 28;
            case ($urandom_range(0, 9))
                0, 1: op = (pending < 0) ? ole_pkg::OP_APPEND
                         : (fill_goal > 10 ? ole_pkg::OP_APPEND : ole_pkg::OP_DEL_POS);
                2: op = ole_pkg::OP_INS_POS;
                3: op = ole_pkg::OP_INS_ID;
                4: op = ole_pkg::OP_DEL_POS;
                5: op = ole_pkg::OP_DEL_ID;
                6: op = ole_pkg::OP_DUMP;
                7: op = 3'($urandom_range(0, 7));
                default: op = fill_goal > 10 ? ole_pkg::OP_INS_POS : ole_pkg::OP_DEL_ID;
            endcase
            send_request(op, 5'($urandom_range(0, 31)), pick_id(),
                         $urandom_range(0, 3) == 0 ? $signed($urandom()) : pick_id());
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("covered %0d requests, %0d dumps, %0d results checked",
                 requests_sent, dumps_seen, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ole_pkg.sv
hw/rtl/ole_mem.sv
hw/rtl/ordered_list_engine.sv
hw/rtl/ole_checker.sv
dv/list_checker.sv
dv/testbench.sv
